### hw/rtl/dqp_pkg.sv
// Shared types and constants for the DNS header and question parser.
// Used by dqp_parser and dns_query_header_question_parser_unit; no dependencies.
`timescale 1ns / 1ps

package dqp_pkg;

    // Longest name in characters, dots included
    localparam int unsigned MAX_NAME = 255;
    localparam int unsigned NAME_LEN_W = 9;

    // Byte index of the last header byte of each header result
    localparam logic [3:0] HDR_FLAGS_POS = 4'd3;
    localparam logic [3:0] HDR_COUNTS_POS = 4'd11;

    // Number of qtype/qclass bytes held before the last one arrives
    localparam logic [7:0] TAIL_HELD = 8'd3;

    // Character emitted between labels
    localparam logic [7:0] NAME_DOT = 8'h2E;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_COUNTS   = 3'd1,
        KIND_NAME_CHR = 3'd2,
        KIND_QTYPE    = 3'd3,
        KIND_TOO_LONG = 3'd4
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic        qr_flag;
        logic [3:0]  op_code;
        logic        aa_flag;
        logic        tc_flag;
        logic        rd_flag;
        logic        ra_flag;
        logic [3:0]  resp_code;
    } result_t;

endpackage

### hw/rtl/dqp_parser.sv
// Parse state and per-byte decode for the DNS header and question parser.
// Depends on dqp_pkg; instantiated by dns_query_header_question_parser_unit.
`timescale 1ns / 1ps

module dqp_parser
    import dqp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       msg_start,
    output result_t    res
);

    phase_t                phase_reg, phase_next;
    logic [3:0]            hpos_reg, hpos_next;
    logic [63:0]           hbytes_reg, hbytes_next;
    logic [15:0]           qleft_reg, qleft_next;
    logic [7:0]            llen_reg, llen_next;
    logic [NAME_LEN_W-1:0] nlen_reg, nlen_next;
    logic                  first_reg, first_next;
    logic [23:0]           tail_reg, tail_next;

    phase_t                eff_phase;
    logic [3:0]            eff_hpos;
    logic [63:0]           eff_hbytes;
    logic [15:0]           eff_qleft;
    logic [7:0]            eff_llen;
    logic [NAME_LEN_W-1:0] eff_nlen;
    logic                  eff_first;
    logic [23:0]           eff_tail;

    logic [63:0]           hb_shift;
    logic [7:0]            f2;
    logic [7:0]            f3;
    logic                  name_full;
    logic [7:0]            llen_dec;
    logic [15:0]           qleft_dec;

    // Start mark restarts all parse state before the byte is used
    assign eff_phase  = msg_start ? PH_HEADER : phase_reg;
    assign eff_hpos   = msg_start ? 4'd0 : hpos_reg;
    assign eff_hbytes = msg_start ? 64'd0 : hbytes_reg;
    assign eff_qleft  = msg_start ? 16'd0 : qleft_reg;
    assign eff_llen   = msg_start ? 8'd0 : llen_reg;
    assign eff_nlen   = msg_start ? '0 : nlen_reg;
    assign eff_first  = msg_start ? 1'b1 : first_reg;
    assign eff_tail   = msg_start ? 24'd0 : tail_reg;

    assign hb_shift  = {eff_hbytes[55:0], data_byte};
    assign f2        = hb_shift[15:8];
    assign f3        = hb_shift[7:0];
    assign name_full = (eff_nlen >= NAME_LEN_W'(MAX_NAME));
    assign llen_dec  = eff_llen - 8'd1;
    assign qleft_dec = eff_qleft - 16'd1;

    // Next parse state
    always_comb
    begin
        phase_next  = eff_phase;
        hpos_next   = eff_hpos;
        hbytes_next = eff_hbytes;
        qleft_next  = eff_qleft;
        llen_next   = eff_llen;
        nlen_next   = eff_nlen;
        first_next  = eff_first;
        tail_next   = eff_tail;
        unique case (eff_phase)
            PH_HEADER:
            begin
                hbytes_next = hb_shift;
                if (eff_hpos == HDR_FLAGS_POS)
                begin
                    hpos_next = eff_hpos + 4'd1;
                end
                else if (eff_hpos == HDR_COUNTS_POS)
                begin
                    qleft_next = hb_shift[63:48];
                    hpos_next  = 4'd0;
                    if (hb_shift[63:48] == 16'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                        nlen_next  = '0;
                        first_next = 1'b1;
                        llen_next  = 8'd0;
                        tail_next  = 24'd0;
                    end
                end
                else
                begin
                    hpos_next = eff_hpos + 4'd1;
                end
            end
            PH_LENGTH:
            begin
                if (data_byte == 8'd0)
                begin
                    phase_next = PH_TAIL;
                    llen_next  = 8'd0;
                    tail_next  = 24'd0;
                end
                else
                begin
                    llen_next  = data_byte;
                    phase_next = PH_LABEL;
                    if (!eff_first)
                    begin
                        if (name_full)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            nlen_next = eff_nlen + NAME_LEN_W'(1);
                        end
                    end
                    else
                    begin
                        first_next = 1'b0;
                    end
                end
            end
            PH_LABEL:
            begin
                if (name_full)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    nlen_next = eff_nlen + NAME_LEN_W'(1);
                    llen_next = llen_dec;
                    if (llen_dec == 8'd0)
                    begin
                        phase_next = PH_LENGTH;
                        first_next = 1'b0;
                    end
                end
            end
            PH_TAIL:
            begin
                if (eff_llen < TAIL_HELD)
                begin
                    tail_next = {eff_tail[15:0], data_byte};
                    llen_next = eff_llen + 8'd1;
                end
                else
                begin
                    qleft_next = qleft_dec;
                    llen_next  = 8'd0;
                    tail_next  = 24'd0;
                    if (qleft_dec == 16'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                        nlen_next  = '0;
                        first_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Result for this byte
    always_comb
    begin
        res = '0;
        unique case (eff_phase)
            PH_HEADER:
            begin
                if (eff_hpos == HDR_FLAGS_POS)
                begin
                    res.valid     = 1'b1;
                    res.kind      = KIND_HEADER;
                    res.word_a    = hb_shift[31:16];
                    res.word_b    = {13'd0, f3[6:4]};
                    res.qr_flag   = f2[7];
                    res.op_code   = f2[6:3];
                    res.aa_flag   = f2[2];
                    res.tc_flag   = f2[1];
                    res.rd_flag   = f2[0];
                    res.ra_flag   = f3[7];
                    res.resp_code = f3[3:0];
                end
                else if (eff_hpos == HDR_COUNTS_POS)
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_COUNTS;
                    res.word_a = hb_shift[63:48];
                    res.word_b = hb_shift[47:32];
                    res.word_c = hb_shift[31:16];
                    res.word_d = hb_shift[15:0];
                end
            end
            PH_LENGTH:
            begin
                if (data_byte != 8'd0 && !eff_first)
                begin
                    res.valid = 1'b1;
                    if (name_full)
                    begin
                        res.kind = KIND_TOO_LONG;
                    end
                    else
                    begin
                        res.kind   = KIND_NAME_CHR;
                        res.word_a = {8'd0, NAME_DOT};
                    end
                end
            end
            PH_LABEL:
            begin
                res.valid = 1'b1;
                if (name_full)
                begin
                    res.kind = KIND_TOO_LONG;
                end
                else
                begin
                    res.kind   = KIND_NAME_CHR;
                    res.word_a = {8'd0, data_byte};
                end
            end
            PH_TAIL:
            begin
                if (eff_llen >= TAIL_HELD)
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_QTYPE;
                    res.word_a = eff_tail[23:8];
                    res.word_b = {eff_tail[7:0], data_byte};
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // Commit state when a byte is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hpos_reg   <= 4'd0;
            hbytes_reg <= 64'd0;
            qleft_reg  <= 16'd0;
            llen_reg   <= 8'd0;
            nlen_reg   <= '0;
            first_reg  <= 1'b1;
            tail_reg   <= 24'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            hbytes_reg <= hbytes_next;
            qleft_reg  <= qleft_next;
            llen_reg   <= llen_next;
            nlen_reg   <= nlen_next;
            first_reg  <= first_next;
            tail_reg   <= tail_next;
        end
    end

endmodule

### hw/rtl/dns_query_header_question_parser_unit.sv
// DNS message header and question parser, streaming top level.
// Depends on dqp_pkg and dqp_parser.
`timescale 1ns / 1ps

// Takes one DNS message byte per transfer (s_tuser marks the first byte of a
// message) and emits header, section count, name character, qtype/qclass and
// name-too-long results. Throughput is one byte per clock while the output is
// not back-pressured; a byte passes an input register and the decode logic
// into the result register. Bytes that cause no result are dropped silently.
// Output back-pressure stalls the input register only when the result
// register is full and not being drained.
module dns_query_header_question_parser_unit
    import dqp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] msg_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] word_a, [31:16] word_b, [47:32] word_c, [63:48] word_d,
    // [64] qr_flag, [68:65] op_code, [69] aa_flag, [70] tc_flag,
    // [71] rd_flag, [72] ra_flag, [76:73] resp_code, [79:77] zero
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser    // [2:0] kind
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_start_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;

    // Move the held byte through decode when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dqp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_data_reg),
        .msg_start (in_start_reg),
        .res       (res)
    );

    // Hold the input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_reg <= res;
        end
    end

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'd0, out_reg.resp_code, out_reg.ra_flag, out_reg.rd_flag,
                       out_reg.tc_flag, out_reg.aa_flag, out_reg.op_code,
                       out_reg.qr_flag, out_reg.word_d, out_reg.word_c,
                       out_reg.word_b, out_reg.word_a};

endmodule
